// File: rtl/wth_pkg.sv
// shared types, constants and the key weight table for the word tokenizer and hash unit
// no dependencies

package wth_pkg;

	localparam int unsigned TABLE_SIZE_DEF   = 599999;
	localparam int unsigned MAX_WORD_LEN_DEF = 50;

	localparam int unsigned HASH_W = 20;
	localparam int unsigned LEN_W  = 6;
	localparam int unsigned CHAR_W = 7;
	localparam int unsigned WSQ_W  = 14;
	localparam int unsigned PROD_W = CHAR_W + WSQ_W;

	// restoring reduction of the product, a few constant compare/subtract steps per stage
	localparam int unsigned RED_STEPS = PROD_W;
	localparam int unsigned RED_PER   = 3;
	localparam int unsigned RED_STG   = (RED_STEPS + RED_PER - 1) / RED_PER;
	localparam int unsigned RED_DW    = PROD_W + HASH_W;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = $clog2(QDEPTH);

	localparam logic [7:0]  ASCII_UP_A = 8'h41;
	localparam logic [7:0]  ASCII_UP_Z = 8'h5A;
	localparam logic [7:0]  ASCII_LO_A = 8'h61;
	localparam logic [7:0]  ASCII_LO_Z = 8'h7A;
	localparam logic [LEN_W-1:0] LEN_SAT = '1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_text;
	} in_beat_t;

	typedef struct packed {
		logic [HASH_W-1:0] word_hash;
		logic [LEN_W-1:0]  word_length;
		logic              too_long;
	} out_beat_t;

	// classified byte as it travels through the queue
	typedef struct packed {
		logic              is_letter;
		logic              eot;
		logic [CHAR_W-1:0] ch;
	} tok_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// squared weights of the key string "Murasame"
	function automatic logic [WSQ_W-1:0] key_wsq(input logic [2:0] pos);
		logic [WSQ_W-1:0] v;
		unique case (pos)
			3'd0: v = 14'd5929;
			3'd1: v = 14'd13689;
			3'd2: v = 14'd12996;
			3'd3: v = 14'd9409;
			3'd4: v = 14'd13225;
			3'd5: v = 14'd9409;
			3'd6: v = 14'd11881;
			3'd7: v = 14'd10201;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/wth_front.sv
// front end: takes text beats, classifies letters and separators, lowercases letters
// depends on wth_pkg

module wth_front (
	input  logic             byte_valid,
	output logic             byte_stall,
	input  wth_pkg::in_beat_t byte_data,
	input  wth_pkg::q_stat_t q_stat,
	output logic             push,
	output wth_pkg::tok_t    push_tok
);
	import wth_pkg::*;

	logic upper;
	logic lower;

	assign upper = (byte_data.data_byte >= ASCII_UP_A) && (byte_data.data_byte <= ASCII_UP_Z);
	assign lower = (byte_data.data_byte >= ASCII_LO_A) && (byte_data.data_byte <= ASCII_LO_Z);

	assign byte_stall = q_stat.full;
	assign push       = byte_valid && !q_stat.full;

	always_comb begin
		push_tok.is_letter = upper || lower;
		push_tok.eot       = byte_data.end_of_text;
		// setting bit 5 lowercases a letter
		push_tok.ch        = byte_data.data_byte[CHAR_W-1:0] | 7'h20;
	end

endmodule

// File: rtl/wth_queue.sv
// short queue of classified bytes between front and back
// depends on wth_pkg

module wth_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  wth_pkg::tok_t    push_tok,
	input  logic             pop,
	output wth_pkg::tok_t    pop_tok,
	output wth_pkg::q_stat_t q_stat
);
	import wth_pkg::*;

	tok_t             mem_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QAW:0]     cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_tok;
	end

	assign pop_tok      = mem_q[rd_ptr_q];
	assign q_stat.full  = (cnt_q == (QAW+1)'(QDEPTH));
	assign q_stat.empty = (cnt_q == '0);

endmodule

// File: rtl/wth_back.sv
// back end: weight multiply, pipelined modulo reduction, word accumulator, output register
// depends on wth_pkg

module wth_back #(
	parameter int unsigned TABLE_SIZE   = wth_pkg::TABLE_SIZE_DEF,
	parameter int unsigned MAX_WORD_LEN = wth_pkg::MAX_WORD_LEN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  wth_pkg::q_stat_t   q_stat,
	input  wth_pkg::tok_t      pop_tok,
	output logic               pop,
	output logic               word_valid,
	input  logic               word_stall,
	output wth_pkg::out_beat_t word_data
);
	import wth_pkg::*;

	localparam logic [RED_DW-1:0] TS_W = RED_DW'(TABLE_SIZE);

	logic adv;

	// stage 1: product of letter and squared weight
	logic [2:0]        pos_q;
	logic              v_s1;
	logic              let_s1;
	logic              eot_s1;
	logic [PROD_W-1:0] prod_s1;

	// reduction stages, index 0 is fed by stage 1
	logic              v_sn   [RED_STG];
	logic              let_sn [RED_STG];
	logic              eot_sn [RED_STG];
	logic [PROD_W-1:0] rem_sn [RED_STG];

	// open word
	logic [HASH_W-1:0] res_q;
	logic [LEN_W-1:0]  cnt_q;
	logic              inword_q;

	logic              out_valid_q;
	out_beat_t         out_data_q;

	assign adv = !out_valid_q || !word_stall;
	assign pop = adv && !q_stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			v_s1  <= 1'b0;
		end else if (adv) begin
			v_s1 <= !q_stat.empty;
			if (!q_stat.empty) begin
				if (pop_tok.is_letter && !pop_tok.eot) pos_q <= pos_q + 1'b1;
				else pos_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			let_s1  <= pop_tok.is_letter;
			eot_s1  <= pop_tok.eot;
			prod_s1 <= PROD_W'(pop_tok.ch) * PROD_W'(key_wsq(pos_q));
		end
	end

	for (genvar g = 0; g < RED_STG; g++) begin : g_red
		logic              v_in;
		logic              let_in;
		logic              eot_in;
		logic [PROD_W-1:0] rem_in;
		logic [PROD_W-1:0] rem_nx;

		if (g == 0) begin : g_first
			assign v_in   = v_s1;
			assign let_in = let_s1;
			assign eot_in = eot_s1;
			assign rem_in = prod_s1;
		end else begin : g_next
			assign v_in   = v_sn[g-1];
			assign let_in = let_sn[g-1];
			assign eot_in = eot_sn[g-1];
			assign rem_in = rem_sn[g-1];
		end

		always_comb begin
			logic [RED_DW-1:0] d;
			rem_nx = rem_in;
			for (int k = 0; k < RED_PER; k++) begin
				if (g * RED_PER + k < RED_STEPS) begin
					d = TS_W << (RED_STEPS - 1 - (g * RED_PER + k));
					if (RED_DW'(rem_nx) >= d) rem_nx = rem_nx - d[PROD_W-1:0];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sn[g] <= 1'b0;
			end else if (adv) begin
				v_sn[g] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				let_sn[g] <= let_in;
				eot_sn[g] <= eot_in;
				rem_sn[g] <= rem_nx;
			end
		end
	end

	// accumulate: one add and one compare against the table size
	logic              v_l;
	logic              close;
	logic [HASH_W:0]   sum;
	logic [HASH_W-1:0] res_nx;
	logic [LEN_W-1:0]  cnt_nx;
	logic              in_nx;

	assign v_l   = v_sn[RED_STG-1];
	assign close = !let_sn[RED_STG-1] || eot_sn[RED_STG-1];
	assign sum   = {1'b0, res_q} + (HASH_W+1)'(rem_sn[RED_STG-1]);

	always_comb begin
		if (let_sn[RED_STG-1]) begin
			res_nx = (sum >= (HASH_W+1)'(TABLE_SIZE)) ?
				HASH_W'(sum - (HASH_W+1)'(TABLE_SIZE)) : sum[HASH_W-1:0];
			cnt_nx = (cnt_q == LEN_SAT) ? cnt_q : cnt_q + 1'b1;
			in_nx  = 1'b1;
		end else begin
			res_nx = res_q;
			cnt_nx = cnt_q;
			in_nx  = inword_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q       <= '0;
			cnt_q       <= '0;
			inword_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_l && close && in_nx;
			if (v_l) begin
				if (close) begin
					res_q    <= '0;
					cnt_q    <= '0;
					inword_q <= 1'b0;
				end else begin
					res_q    <= res_nx;
					cnt_q    <= cnt_nx;
					inword_q <= in_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q.word_hash   <= res_nx;
			out_data_q.word_length <= cnt_nx;
			out_data_q.too_long    <= (cnt_nx > LEN_W'(MAX_WORD_LEN));
		end
	end

	assign word_valid = out_valid_q;
	assign word_data  = out_data_q;

endmodule

// File: rtl/word_tokenize_and_hash_unit.sv
// top level of the word tokenizer and hash unit
// depends on wth_pkg, wth_front, wth_queue, wth_back

// Takes a text stream one byte beat per cycle and returns one beat per finished word
// carrying its hash, letter count (saturating at 63) and a too-long flag. Letters A-Z and
// a-z form words, any other byte closes an open word, and end_of_text closes the word after
// hashing its own byte if that byte is a letter. Each letter is lowercased and multiplied by
// the square of a weight from the key "Murasame" picked by position in the word, and the
// products are summed modulo TABLE_SIZE. Throughput is one byte per cycle, sustained while
// the output side keeps up; word_valid rises once the closing byte has passed from the
// queue through the multiply register, the restoring reduction stages, then the
// accumulator/output register. The rate is set by the accumulator, which folds one
// reduced product into the running residue per cycle with one add and one compare. A
// four-beat queue separates the input from the arithmetic pipeline, so up to four more
// beats are taken while a finished word beat waits. No clearing pass after reset.

module word_tokenize_and_hash_unit #(
	parameter int unsigned TABLE_SIZE   = wth_pkg::TABLE_SIZE_DEF,
	parameter int unsigned MAX_WORD_LEN = wth_pkg::MAX_WORD_LEN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  wth_pkg::in_beat_t  byte_data,
	output logic               word_valid,
	input  logic               word_stall,
	output wth_pkg::out_beat_t word_data
);
	import wth_pkg::*;

	q_stat_t q_stat;
	logic    push;
	logic    pop;
	tok_t    push_tok;
	tok_t    pop_tok;

	// classify and lowercase incoming beats
	wth_front u_front (
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.q_stat     (q_stat),
		.push       (push),
		.push_tok   (push_tok)
	);

	// decouples the input handshake from the arithmetic pipeline
	wth_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_tok (push_tok),
		.pop      (pop),
		.pop_tok  (pop_tok),
		.q_stat   (q_stat)
	);

	// multiply, reduce, accumulate, and hold the word beat
	wth_back #(
		.TABLE_SIZE   (TABLE_SIZE),
		.MAX_WORD_LEN (MAX_WORD_LEN)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.pop_tok    (pop_tok),
		.pop        (pop),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.word_data  (word_data)
	);

`ifndef SYNTHESIS
	// queue can't claim full and empty at once
	a_q_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue full and empty together");

	// at most one pop per cycle, so a full queue is never empty next cycle
	a_q_drain: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |=> !q_stat.empty)
		else $error("queue drained too fast");

	// reported hash is fully reduced
	a_hash_range: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid |-> (word_data.word_hash < HASH_W'(TABLE_SIZE)))
		else $error("word hash not reduced");

	// a reported word has at least one letter
	a_len_nz: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid |-> (word_data.word_length != '0))
		else $error("empty word reported");
`endif

endmodule

// File: test/word_tokenize_and_hash_unit_tb.sv
// testbench for word_tokenize_and_hash_unit: directed byte table, then random word streams
// depends on wth_pkg and the rtl of word_tokenize_and_hash_unit
`timescale 1ns / 100ps

module word_tokenize_and_hash_unit_tb;
	import wth_pkg::*;

	localparam int unsigned TABLE_MODULUS = 599999;
	localparam int unsigned LONG_LIMIT  = 50;
	localparam int unsigned CYCLE_LIMIT = 400000;
	// settle wait, a good margin past the pipeline latency
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned RANDOM_ITEMS  = 1100;

	// key "Murasame" as ascii weights, squared at use
	localparam int unsigned KEY_WEIGHT [8] = '{77, 117, 114, 97, 115, 97, 109, 101};

	// how a directed row is checked
	typedef enum logic [1:0] {
		ROW_PREDICT,	// expectation from the hash predictor
		ROW_NONE,	// typed in: no word beat
		ROW_WORD	// typed in: this word beat
	} row_kind_t;

	typedef struct {
		in_beat_t  beat;
		row_kind_t kind;
		out_beat_t want;
	} stim_row_t;

	localparam int NUM_ROWS = 25;

	// directed bytes: extremes of the letter ranges, their neighbors, 0x00 and 0xff,
	// end of text on letters and separators, a word longer than the key
	stim_row_t dir_rows [NUM_ROWS] = '{
		'{'{8'h20, 1'b0}, ROW_NONE,    '{20'd0, 6'd0, 1'b0}},	// separator outside word
		'{'{8'h00, 1'b1}, ROW_NONE,    '{20'd0, 6'd0, 1'b0}},	// end of text, no word open
		'{'{8'hFF, 1'b0}, ROW_NONE,    '{20'd0, 6'd0, 1'b0}},
		'{'{8'h61, 1'b1}, ROW_WORD,    '{20'd575113, 6'd1, 1'b0}},	// 'a' = 97 * 77^2
		'{'{8'h41, 1'b1}, ROW_WORD,    '{20'd575113, 6'd1, 1'b0}},	// 'A' folds to 'a'
		'{'{8'h7A, 1'b1}, ROW_WORD,    '{20'd123339, 6'd1, 1'b0}},	// 'z', one wrap of the modulus
		'{'{8'h5A, 1'b0}, ROW_NONE,    '{20'd0, 6'd0, 1'b0}},	// 'Z' opens a word
		'{'{8'h40, 1'b0}, ROW_WORD,    '{20'd123339, 6'd1, 1'b0}},	// '@' just below 'A' closes it
		'{'{8'h5B, 1'b0}, ROW_NONE,    '{20'd0, 6'd0, 1'b0}},	// just above 'Z'
		'{'{8'h60, 1'b0}, ROW_NONE,    '{20'd0, 6'd0, 1'b0}},	// just below 'a'
		'{'{8'h7B, 1'b0}, ROW_NONE,    '{20'd0, 6'd0, 1'b0}},	// just above 'z'
		'{'{8'h4D, 1'b0}, ROW_PREDICT, '{20'd0, 6'd0, 1'b0}},	// nine letters, key wraps once
		'{'{8'h75, 1'b0}, ROW_PREDICT, '{20'd0, 6'd0, 1'b0}},
		'{'{8'h72, 1'b0}, ROW_PREDICT, '{20'd0, 6'd0, 1'b0}},
		'{'{8'h61, 1'b0}, ROW_PREDICT, '{20'd0, 6'd0, 1'b0}},
		'{'{8'h73, 1'b0}, ROW_PREDICT, '{20'd0, 6'd0, 1'b0}},
		'{'{8'h61, 1'b0}, ROW_PREDICT, '{20'd0, 6'd0, 1'b0}},
		'{'{8'h6D, 1'b0}, ROW_PREDICT, '{20'd0, 6'd0, 1'b0}},
		'{'{8'h65, 1'b0}, ROW_PREDICT, '{20'd0, 6'd0, 1'b0}},
		'{'{8'h78, 1'b0}, ROW_PREDICT, '{20'd0, 6'd0, 1'b0}},
		'{'{8'hFF, 1'b0}, ROW_PREDICT, '{20'd0, 6'd0, 1'b0}},	// 0xff closes like any separator
		'{'{8'h51, 1'b0}, ROW_PREDICT, '{20'd0, 6'd0, 1'b0}},
		'{'{8'h80, 1'b1}, ROW_PREDICT, '{20'd0, 6'd0, 1'b0}},	// end of text on a separator
		'{'{8'h7F, 1'b1}, ROW_NONE,    '{20'd0, 6'd0, 1'b0}},	// end of text right after
		'{'{8'h62, 1'b1}, ROW_PREDICT, '{20'd0, 6'd0, 1'b0}}	// one-letter stream
	};

	logic      clk;
	logic      arst_n;
	logic      byte_valid;
	logic      byte_stall;
	in_beat_t  byte_data;
	logic      word_valid;
	logic      word_stall;
	out_beat_t word_data;

	word_tokenize_and_hash_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.word_data  (word_data)
	);

	// predictor state of the open word
	int unsigned word_residue;
	logic [2:0]  key_pos;
	bit          in_word;
	int unsigned letters_seen;

	out_beat_t   word_expect_q [$];
	int unsigned errors;
	int unsigned beats_sent;
	int unsigned words_checked;
	int unsigned long_words;
	int unsigned cycle_count;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;

	function automatic bit is_letter(input logic [7:0] b);
		return (b >= ASCII_UP_A && b <= ASCII_UP_Z) || (b >= ASCII_LO_A && b <= ASCII_LO_Z);
	endfunction

	// advance the word hash by one accepted byte, report a finished word if one closes
	task automatic hash_step(input in_beat_t b, output bit closes_word, output out_beat_t w);
		int unsigned ch;
		int unsigned wt;
		bit          letter;
		letter = is_letter(b.data_byte);
		closes_word = 1'b0;
		w = '0;
		if (letter) begin
			ch = (b.data_byte <= ASCII_UP_Z) ? b.data_byte + 32 : b.data_byte;
			wt = KEY_WEIGHT[key_pos];
			word_residue = (word_residue + ch * wt * wt) % TABLE_MODULUS;
			key_pos = key_pos + 3'd1;
			if (letters_seen < 63)
				letters_seen++;
			in_word = 1'b1;
		end
		// a separator or end of text closes the word, then everything clears
		if (!letter || b.end_of_text) begin
			if (in_word) begin
				closes_word   = 1'b1;
				w.word_hash   = word_residue[HASH_W-1:0];
				w.word_length = letters_seen[LEN_W-1:0];
				w.too_long    = (letters_seen > LONG_LIMIT);
			end
			word_residue = 0;
			key_pos      = '0;
			in_word      = 1'b0;
			letters_seen = 0;
		end
	endtask

	// entered and left at a falling edge; holds the beat until it is taken
	task automatic send_byte(input in_beat_t b, input row_kind_t kind, input out_beat_t typed);
		bit        closes_word;
		out_beat_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid <= 1'b1;
		byte_data  <= b;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		beats_sent++;
		hash_step(b, closes_word, predicted);
		case (kind)
			ROW_WORD: word_expect_q.push_back(typed);
			ROW_NONE: ;
			default: if (closes_word) word_expect_q.push_back(predicted);
		endcase
		@(negedge clk);
	endtask

	function automatic logic [7:0] pick_letter();
		return 8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? ASCII_UP_A : ASCII_LO_A);
	endfunction

	function automatic logic [7:0] pick_separator();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (is_letter(b));
		return b;
	endfunction

	// hold off the sender until every word beat is back, then let the pipe settle
	task automatic drain_words();
		byte_valid <= 1'b0;
		while (word_expect_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// mostly well formed words with random case and length, some raw noise between them
	task automatic random_text(input int unsigned quota);
		int unsigned sent;
		int unsigned len;
		int unsigned pick;
		in_beat_t    b;
		sent = 0;
		while (sent < quota) begin
			if ($urandom_range(0, 99) < 15) begin
				// noise: any byte, end of text now and then
				repeat ($urandom_range(1, 4)) begin
					b.data_byte   = 8'($urandom_range(0, 255));
					b.end_of_text = ($urandom_range(0, 7) == 0);
					send_byte(b, ROW_PREDICT, '0);
					sent++;
				end
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 8)
					len = $urandom_range(45, 75);	// long words, past saturation too
				else if (pick < 10)
					len = $urandom_range(50, 51);	// right at the too-long boundary
				else
					len = $urandom_range(1, 12);
				for (int unsigned i = 0; i < len; i++) begin
					b.data_byte   = pick_letter();
					b.end_of_text = (i == len - 1) && ($urandom_range(0, 5) == 0);
					send_byte(b, ROW_PREDICT, '0);
					sent++;
				end
				// close with a separator unless end of text already did
				if (!b.end_of_text) begin
					b.data_byte   = pick_separator();
					b.end_of_text = ($urandom_range(0, 5) == 0);
					send_byte(b, ROW_PREDICT, '0);
					sent++;
				end
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver side: stall decided at the falling edge, beat taken at the rising edge
	always @(negedge clk)
		word_stall <= ($urandom_range(0, 99) < recv_stall_pct);

	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && word_valid && !word_stall) begin
			if (word_expect_q.size() == 0) begin
				errors++;
				$display("%0t: expected no word beat, actual hash %0d len %0d long %0b", $time,
					word_data.word_hash, word_data.word_length, word_data.too_long);
			end else begin
				want = word_expect_q.pop_front();
				words_checked++;
				if (want.too_long)
					long_words++;
				if (word_data.word_hash !== want.word_hash) begin
					errors++;
					$display("%0t: word_hash expected %0d actual %0d", $time,
						want.word_hash, word_data.word_hash);
				end
				if (word_data.word_length !== want.word_length) begin
					errors++;
					$display("%0t: word_length expected %0d actual %0d", $time,
						want.word_length, word_data.word_length);
				end
				if (word_data.too_long !== want.too_long) begin
					errors++;
					$display("%0t: too_long expected %0b actual %0b", $time,
						want.too_long, word_data.too_long);
				end
			end
		end
	end

	// watchdog on the whole run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d word beats still outstanding", $time,
				word_expect_q.size());
			$display("word_tokenize_and_hash_unit verification failed");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		byte_valid     = 1'b0;
		byte_data      = '0;
		word_stall     = 1'b0;
		word_residue   = 0;
		key_pos        = '0;
		in_word        = 1'b0;
		letters_seen   = 0;
		errors         = 0;
		beats_sent     = 0;
		words_checked  = 0;
		long_words     = 0;
		cycle_count    = 0;
		// sender rarely idle, receiver mostly stalled
		send_idle_pct  = 7;
		recv_stall_pct = 77;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < NUM_ROWS; i++)
			send_byte(dir_rows[i].beat, dir_rows[i].kind, dir_rows[i].want);
		random_text(RANDOM_ITEMS / 3);
		drain_words();

		// sender mostly idle, receiver rarely stalled
		send_idle_pct  = 77;
		recv_stall_pct = 7;
		random_text(RANDOM_ITEMS / 3);
		drain_words();

		// full rate both ways
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		random_text(RANDOM_ITEMS / 3);
		drain_words();

		$display("sent %0d byte beats, checked %0d word beats, %0d of them over the length limit",
			beats_sent, words_checked, long_words);
		$display("stall mixes: slow receiver, slow sender, and both at full rate");
		if (errors == 0)
			$display("word_tokenize_and_hash_unit verification clean");
		else
			$display("word_tokenize_and_hash_unit verification failed");
		$finish;
	end

endmodule
